### rtl/pbrt_pkg.sv
// Shared constants, types and helpers for the pulse beat rate tracker.
package pbrt_pkg;

    localparam int WINDOW      = 9;
    localparam int SAMPLE_BITS = 18;
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int POS_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [REG_IDX_W-1:0] REG_SESSION_EN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REFRACTORY = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_JUMP   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_JUMP_PER_S = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_BEATS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BPM_LOW    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BPM_HIGH   = 3'd6;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_NO_RED   = 3'd1;
    localparam logic [2:0] EV_RANGE    = 3'd2;
    localparam logic [2:0] EV_JUMP     = 3'd3;
    localparam logic [2:0] EV_KEPT     = 3'd4;

    localparam logic [16:0] HP_COEF     = 17'd63570;
    localparam logic [16:0] SLOPE_KEEP  = 17'd45875;
    localparam logic [16:0] SLOPE_GAIN  = 17'd19661;
    localparam logic [31:0] RATE_NUM    = 32'd960000;
    localparam logic [19:0] RATE_MAX    = 20'd960000;

    // value moving along the median chain
    typedef struct packed {
        logic       vld;
        logic [7:0] val;
    } t_circ;

    typedef struct packed {
        logic wr;
        logic load;
        logic step;
    } t_cell_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/pbrt_in_if.sv
// Sample channel: paired optical readings with time stamp.
interface pbrt_in_if;
    import pbrt_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] ir_sample;
    logic [SAMPLE_BITS-1:0] red_sample;
    logic [31:0]            time_ms;

    modport source (output valid, ir_sample, red_sample, time_ms, input ready);
    modport sink   (input valid, ir_sample, red_sample, time_ms, output ready);
endinterface

### rtl/pbrt_out_if.sv
// Result channel: beat event, rates and filtered infrared value.
interface pbrt_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic [19:0]        beat_rate;
    logic [7:0]         median_rate;
    logic [3:0]         kept_count;
    logic signed [31:0] ir_filtered;

    modport source (output valid, event_res, beat_rate, median_rate, kept_count, ir_filtered,
                    input ready);
    modport sink   (input valid, event_res, beat_rate, median_rate, kept_count, ir_filtered,
                    output ready);
endinterface

### rtl/pulse_beat_rate_tracker.sv
// Pulse beat rate tracker: band filters, beat detection, rate check and running median.
//
// Usage: samples enter on i_in (valid/ready); one result per sample leaves on o_out.
// Configuration registers are written on i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Each sample is processed by a sequencer sharing one 33x18 multiplier. Its path from
// the accepting edge to o_out.valid:
//   - session disabled: straight to the output state.
//   - no beat candidate or no red corroboration: filter, slope and check states.
//   - scored beat: the serial divider for 960000/interval in 1/16 beats per minute
//     (skipped for a zero interval), a range check state and, with enough kept beats,
//     a jump check state; a range reject ends there. A kept beat passes KEEP, MLD,
//     MED and SEL while the rate ring circulates the chain of cells to rank every entry.
// One sample is in work at a time; i_in.ready is high only when the sequencer is idle,
// so the next sample is accepted in the cycle after a result is registered.
// A finished result sits in the output register; the next sample can be accepted and
// processed, and it waits at the end until the receiver has taken the earlier one.
// Reset clears filter state, time stamps, ring fill and median, and loads the
// register defaults; ring contents are not cleared, only filled slots are ranked.
module pulse_beat_rate_tracker import pbrt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pbrt_in_if.sink               i_in,
    pbrt_out_if.source            o_out
);
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_IRM  = 5'd1;
    localparam logic [4:0] ST_IRY  = 5'd2;
    localparam logic [4:0] ST_IRL  = 5'd3;
    localparam logic [4:0] ST_RDM  = 5'd4;
    localparam logic [4:0] ST_RDY  = 5'd5;
    localparam logic [4:0] ST_RDL  = 5'd6;
    localparam logic [4:0] ST_SM1  = 5'd7;
    localparam logic [4:0] ST_SM2  = 5'd8;
    localparam logic [4:0] ST_SLP  = 5'd9;
    localparam logic [4:0] ST_CHK  = 5'd10;
    localparam logic [4:0] ST_DIV  = 5'd11;
    localparam logic [4:0] ST_RNG  = 5'd12;
    localparam logic [4:0] ST_JMP  = 5'd13;
    localparam logic [4:0] ST_KEEP = 5'd14;
    localparam logic [4:0] ST_MLD  = 5'd15;
    localparam logic [4:0] ST_MED  = 5'd16;
    localparam logic [4:0] ST_SEL  = 5'd17;
    localparam logic [4:0] ST_OUT  = 5'd18;

    // configuration
    logic        r_en;
    logic [10:0] r_refr;
    logic [7:0]  r_mj;
    logic [7:0]  r_jps;
    logic [3:0]  r_minb;
    logic [7:0]  r_low;
    logic [7:0]  r_high;

    logic [4:0]             r_state;
    logic [SAMPLE_BITS-1:0] r_ir_raw, r_red_raw, r_ir_in, r_red_in;
    logic [31:0]            r_now, r_last_beat, r_last_kept;
    logic signed [31:0]     r_ir_hp, r_ir_lp, r_red_hp, r_red_lp, r_slope;
    logic signed [31:0]     r_ir_prev, r_red_prev;
    logic signed [50:0]     r_prod, r_acc;
    logic [19:0]            r_rate;
    logic [2:0]             r_event;
    logic [POS_W-1:0]       r_pos;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_step;
    logic [7:0]             r_median;

    logic               r_ovalid;
    logic [2:0]         r_o_event;
    logic [19:0]        r_o_rate;
    logic [7:0]         r_o_median;
    logic [3:0]         r_o_count;
    logic signed [31:0] r_o_irf;

    // shared multiplier operands
    logic signed [32:0] mul_a;
    logic [16:0]        mul_b;

    logic                   is_red;
    logic [SAMPLE_BITS-1:0] cur_raw, cur_in;
    logic signed [31:0]     cur_hp, cur_lp;
    logic signed [51:0]     x_ext, p_ext, t_ext, lp_sum, s_sum;
    logic signed [31:0]     y_new, lp_new, slope_new;
    logic signed [32:0]     d_red;
    logic [31:0]            dt, el;
    logic                   cand, out_free;
    logic [11:0]            med16;
    logic [19:0]            diff;
    logic [29:0]            lhs;
    logic [44:0]            rhs;
    logic                   reject, out_of_range;

    logic                   div_start, div_busy;
    logic [19:0]            div_quot;

    t_cell_ctl        cell_ctl [WINDOW];
    t_circ            circ_out [WINDOW];
    logic [7:0]       cell_val [WINDOW];
    logic [CNT_W-1:0] cell_lt  [WINDOW];
    logic [CNT_W-1:0] cell_le  [WINDOW];
    logic [7:0]       med_pick;
    logic [CNT_W-1:0] med_k;

    assign i_in.ready = r_state == ST_IDLE;
    assign out_free   = !r_ovalid || o_out.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b1;
            r_refr <= 11'd300;
            r_mj   <= 8'd10;
            r_jps  <= 8'd5;
            r_minb <= 4'd3;
            r_low  <= 8'd42;
            r_high <= 8'd220;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SESSION_EN: r_en   <= i_cfg_data[0];
                REG_REFRACTORY: r_refr <= i_cfg_data[10:0];
                REG_MAX_JUMP:   r_mj   <= i_cfg_data[7:0];
                REG_JUMP_PER_S: r_jps  <= i_cfg_data[7:0];
                REG_MIN_BEATS:  r_minb <= i_cfg_data[3:0];
                REG_BPM_LOW:    r_low  <= i_cfg_data[7:0];
                REG_BPM_HIGH:   r_high <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // datapath
    always_comb begin
        is_red  = (r_state == ST_RDY) || (r_state == ST_RDL);
        cur_raw = is_red ? r_red_raw : r_ir_raw;
        cur_in  = is_red ? r_red_in : r_ir_in;
        cur_hp  = is_red ? r_red_hp : r_ir_hp;
        cur_lp  = is_red ? r_red_lp : r_ir_lp;
        x_ext   = $signed({{(44 - SAMPLE_BITS){1'b0}}, cur_raw, 8'b0});
        p_ext   = $signed({{(44 - SAMPLE_BITS){1'b0}}, cur_in, 8'b0});
        t_ext   = ($signed({r_prod[50], r_prod}) + 52'sd32768) >>> 16;
        y_new   = sat32(x_ext - p_ext + t_ext);
        lp_sum  = $signed({{20{cur_lp[31]}}, cur_lp}) * 52'sd3
                  + $signed({{20{cur_hp[31]}}, cur_hp}) + 52'sd2;
        lp_new  = sat32(lp_sum >>> 2);
        d_red   = $signed({r_red_lp[31], r_red_lp}) - $signed({r_red_prev[31], r_red_prev});
        s_sum   = $signed({r_acc[50], r_acc}) + $signed({r_prod[50], r_prod}) + 52'sd32768;
        slope_new = sat32(s_sum >>> 16);

        dt   = r_now - r_last_beat;
        el   = r_now - r_last_kept;
        cand = (r_ir_prev <= 32'sd0) && (r_ir_lp > 32'sd0) && (dt >= {21'b0, r_refr});
        out_of_range = (r_rate <= {8'b0, r_low, 4'b0}) || (r_rate >= {8'b0, r_high, 4'b0});

        med16  = {r_median, 4'b0};
        diff   = (r_rate >= {8'b0, med16}) ? (r_rate - {8'b0, med16})
                                           : ({8'b0, med16} - r_rate);
        lhs    = 30'(diff * 30'd1000);
        rhs    = ({27'b0, r_mj} * 45'd1000 + {4'b0, r_prod[40:0]}) << 4;
        reject = {15'b0, lhs} > rhs;

        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_IRM: begin
                mul_a = {r_ir_hp[31], r_ir_hp};
                mul_b = HP_COEF;
            end
            ST_RDM: begin
                mul_a = {r_red_hp[31], r_red_hp};
                mul_b = HP_COEF;
            end
            ST_SM1: begin
                mul_a = {r_slope[31], r_slope};
                mul_b = SLOPE_KEEP;
            end
            ST_SM2: begin
                mul_a = d_red;
                mul_b = SLOPE_GAIN;
            end
            ST_RNG: begin
                mul_a = $signed({1'b0, el});
                mul_b = {9'b0, r_jps};
            end
            default: ;
        endcase
    end

    assign div_start = (r_state == ST_CHK) && cand && (r_slope > 32'sd0) && (dt != 32'd0);

    pbrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (RATE_NUM + {1'b0, dt[31:1]}),
        .i_den   (dt),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, mul_b});
    end

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ir_in     <= '0;
            r_red_in    <= '0;
            r_ir_hp     <= '0;
            r_ir_lp     <= '0;
            r_red_hp    <= '0;
            r_red_lp    <= '0;
            r_slope     <= '0;
            r_last_beat <= '0;
            r_last_kept <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_median    <= '0;
            r_step      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_ir_raw  <= i_in.ir_sample;
                        r_red_raw <= i_in.red_sample;
                        r_now     <= i_in.time_ms;
                        r_event   <= EV_NONE;
                        r_rate    <= '0;
                        r_state   <= r_en ? ST_IRM : ST_OUT;
                    end
                end
                ST_IRM: r_state <= ST_IRY;
                ST_IRY: begin
                    r_ir_hp   <= y_new;
                    r_ir_in   <= r_ir_raw;
                    r_ir_prev <= r_ir_lp;
                    r_state   <= ST_IRL;
                end
                ST_IRL: begin
                    r_ir_lp <= lp_new;
                    r_state <= ST_RDM;
                end
                ST_RDM: r_state <= ST_RDY;
                ST_RDY: begin
                    r_red_hp   <= y_new;
                    r_red_in   <= r_red_raw;
                    r_red_prev <= r_red_lp;
                    r_state    <= ST_RDL;
                end
                ST_RDL: begin
                    r_red_lp <= lp_new;
                    r_state  <= ST_SM1;
                end
                ST_SM1: r_state <= ST_SM2;
                ST_SM2: begin
                    r_acc   <= r_prod;
                    r_state <= ST_SLP;
                end
                ST_SLP: begin
                    r_slope <= slope_new;
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (!cand) begin
                        r_state <= ST_OUT;
                    end else if (r_slope <= 32'sd0) begin
                        r_event <= EV_NO_RED;
                        r_state <= ST_OUT;
                    end else if (dt == 32'd0) begin
                        r_rate  <= RATE_MAX;
                        r_state <= ST_RNG;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!div_busy) begin
                        r_rate  <= div_quot;
                        r_state <= ST_RNG;
                    end
                end
                ST_RNG: begin
                    r_last_beat <= r_now;
                    if (out_of_range) begin
                        r_event <= EV_RANGE;
                        r_state <= ST_OUT;
                    end else if (8'(r_count) >= 8'(r_minb)) begin
                        r_state <= ST_JMP;
                    end else begin
                        r_state <= ST_KEEP;
                    end
                end
                ST_JMP: begin
                    if (reject) begin
                        r_event <= EV_JUMP;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_KEEP;
                    end
                end
                ST_KEEP: begin
                    r_event     <= EV_KEPT;
                    r_last_kept <= r_now;
                    r_pos       <= (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + POS_W'(1);
                    if (r_count != CNT_W'(WINDOW)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= ST_MLD;
                end
                ST_MLD: begin
                    r_step  <= '0;
                    r_state <= ST_MED;
                end
                ST_MED: begin
                    r_step <= r_step + CNT_W'(1);
                    if (r_step == CNT_W'(WINDOW - 1)) begin
                        r_state <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    r_median <= med_pick;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // chain of ring cells; each value circulates once past every slot
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            localparam int PREV = (gi + WINDOW - 1) % WINDOW;
            assign cell_ctl[gi] = '{wr:   (r_state == ST_KEEP) && (r_pos == POS_W'(gi)),
                                    load: r_state == ST_MLD,
                                    step: r_state == ST_MED};
            pbrt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl[gi]),
                .i_wr_val   (r_rate[11:4]),
                .i_load_vld (CNT_W'(gi) < r_count),
                .i_circ     (circ_out[PREV]),
                .o_circ     (circ_out[gi]),
                .o_val      (cell_val[gi]),
                .o_lt       (cell_lt[gi]),
                .o_le       (cell_le[gi])
            );
        end
    endgenerate

    // median: the filled slot whose rank range covers count/2
    assign med_k = r_count >> 1;
    always_comb begin
        med_pick = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if ((CNT_W'(i) < r_count) && (cell_lt[i] <= med_k) && (cell_le[i] > med_k)) begin
                med_pick = med_pick | cell_val[i];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_o_event  <= r_event;
            r_o_rate   <= r_rate;
            r_o_median <= r_median;
            r_o_count  <= 4'(r_count);
            r_o_irf    <= r_ir_lp;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.event_res   = r_o_event;
    assign o_out.beat_rate   = r_o_rate;
    assign o_out.median_rate = r_o_median;
    assign o_out.kept_count  = r_o_count;
    assign o_out.ir_filtered = r_o_irf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(WINDOW)) && (r_pos < POS_W'(WINDOW)))
        else $error("ring fill or position out of range");

    a_kept_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.event_res == EV_KEPT)) |-> (o_out.kept_count != 4'd0))
        else $error("kept beat reported with empty ring");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_DIV) |-> div_busy)
        else $error("divider idle when rate division starts");

endmodule

### rtl/pbrt_div.sv
// Restoring divider, one quotient bit per cycle.
module pbrt_div import pbrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [19:0] o_quot
);
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_den;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem[31:0], r_q[31]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_cnt != 6'd0) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_q   <= {r_q[30:0], fits};
        end
    end

    assign o_busy = r_cnt != 6'd0;
    assign o_quot = r_q[19:0];
endmodule

### rtl/pbrt_cell.sv
// One ring slot of the median chain: holds a rate and ranks it against passing values.
module pbrt_cell import pbrt_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [7:0]       i_wr_val,
    input  logic             i_load_vld,
    input  t_circ            i_circ,
    output t_circ            o_circ,
    output logic [7:0]       o_val,
    output logic [CNT_W-1:0] o_lt,
    output logic [CNT_W-1:0] o_le
);
    logic [7:0]       r_val;
    t_circ            r_circ;
    logic [CNT_W-1:0] r_lt;
    logic [CNT_W-1:0] r_le;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_val <= i_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_circ <= '{vld: i_load_vld, val: r_val};
            r_lt   <= '0;
            r_le   <= '0;
        end else if (i_ctl.step) begin
            r_circ <= i_circ;
            if (r_circ.vld && (r_circ.val < r_val)) begin
                r_lt <= r_lt + CNT_W'(1);
            end
            if (r_circ.vld && (r_circ.val <= r_val)) begin
                r_le <= r_le + CNT_W'(1);
            end
        end
    end

    assign o_circ = r_circ;
    assign o_val  = r_val;
    assign o_lt   = r_lt;
    assign o_le   = r_le;
endmodule

### bench/tb_pulse_beat_rate_tracker.sv
// Self-checking testbench for the pulse beat rate tracker.
`timescale 1ns / 1ps

module tb_pulse_beat_rate_tracker;
    import pbrt_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [REG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pbrt_in_if  in_if ();
    pbrt_out_if out_if ();

    pulse_beat_rate_tracker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    typedef struct {
        logic [2:0]         ev;
        logic [19:0]        rate;
        logic [7:0]         med;
        logic [3:0]         cnt;
        logic signed [31:0] irf;
    } t_beat_result;

    int errors;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class t_beat_scoreboard;
        // configuration copy
        bit        en;
        bit [10:0] refr;
        bit [7:0]  max_jump, jump_ps, bpm_lo, bpm_hi;
        bit [3:0]  min_beats;
        // filter state, index 0 infrared, 1 red
        bit [17:0]          hp_in [2];
        logic signed [31:0] hp_out[2];
        logic signed [31:0] lp    [2];
        logic signed [31:0] slope;
        bit [31:0] last_beat, last_kept;
        bit [7:0]  ring[WINDOW];
        int        pos, count;
        bit [7:0]  median;
        t_beat_result pending[$];

        function new();
            en = 1; refr = 300; max_jump = 10; jump_ps = 5; min_beats = 3;
            bpm_lo = 42; bpm_hi = 220;
            for (int c = 0; c < 2; c++) begin
                hp_in[c] = 0; hp_out[c] = 0; lp[c] = 0;
            end
            slope = 0; last_beat = 0; last_kept = 0;
            pos = 0; count = 0; median = 0;
        endfunction

        function logic signed [31:0] sat(input longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function logic signed [31:0] band(input int c, input bit [17:0] raw);
            longint y;
            y = longint'(raw) * 256 - longint'(hp_in[c]) * 256
                + ((longint'(hp_out[c]) * 63570 + 32768) >>> 16);
            hp_out[c] = sat(y);
            lp[c] = sat((3 * longint'(lp[c]) + longint'(hp_out[c]) + 2) >>> 2);
            hp_in[c] = raw;
            return lp[c];
        endfunction

        function void rank();
            int s[WINDOW];
            int t;
            for (int i = 0; i < count; i++) s[i] = ring[i];
            for (int i = 0; i < count; i++)
                for (int j = 0; j + 1 < count - i; j++)
                    if (s[j] > s[j+1]) begin
                        t = s[j]; s[j] = s[j+1]; s[j+1] = t;
                    end
            median = 8'(s[count/2]);
        endfunction

        function void note(input bit [17:0] ir, input bit [17:0] red, input bit [31:0] now);
            t_beat_result r;
            logic signed [31:0] ir_prev, red_prev, redf;
            bit [31:0] dt, el;
            longint rate, diff, lim;
            r.ev = EV_NONE; r.rate = 0; r.irf = lp[0];
            if (en) begin
                ir_prev = lp[0]; red_prev = lp[1];
                r.irf = band(0, ir);
                redf = band(1, red);
                slope = sat((longint'(slope) * 45875
                             + (longint'(redf) - longint'(red_prev)) * 19661 + 32768) >>> 16);
                dt = now - last_beat;
                if (ir_prev <= 0 && r.irf > 0 && dt >= refr) begin
                    if (slope <= 0) begin
                        r.ev = EV_NO_RED;
                    end else begin
                        rate = (dt == 0) ? 960000 : (960000 + longint'(dt / 2)) / longint'(dt);
                        r.rate = rate[19:0];
                        last_beat = now;
                        if (rate <= longint'(bpm_lo) * 16 || rate >= longint'(bpm_hi) * 16) begin
                            r.ev = EV_RANGE;
                        end else begin
                            r.ev = EV_KEPT;
                            if (count >= min_beats) begin
                                diff = rate - longint'(median) * 16;
                                if (diff < 0) diff = -diff;
                                el = now - last_kept;
                                lim = (longint'(max_jump) * 1000 + longint'(jump_ps) * el) * 16;
                                if (diff * 1000 > lim) r.ev = EV_JUMP;
                            end
                            if (r.ev == EV_KEPT) begin
                                last_kept = now;
                                ring[pos] = rate[11:4];
                                pos = (pos + 1) % WINDOW;
                                if (count < WINDOW) count++;
                                rank();
                            end
                        end
                    end
                end
            end
            r.med = median; r.cnt = 4'(count);
            pending.push_back(r);
        endfunction

        task check(input t_beat_result got);
            t_beat_result w;
            if (pending.size() == 0) begin
                report("unexpected transaction", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.ev   !== w.ev)   report("event_res",   got.ev,   w.ev);
            if (got.rate !== w.rate) report("beat_rate",   got.rate, w.rate);
            if (got.med  !== w.med)  report("median_rate", got.med,  w.med);
            if (got.cnt  !== w.cnt)  report("kept_count",  got.cnt,  w.cnt);
            if (got.irf  !== w.irf)  report("ir_filtered", got.irf,  w.irf);
        endtask
    endclass

    t_beat_scoreboard sb = new();

    int  send_idle_pct, recv_stall_pct;
    bit  hold_off;
    int  sent;
    bit [31:0] clock_ms;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    always @(posedge i_clk) begin
        if (in_if.valid && in_if.ready)
            sb.note(in_if.ir_sample, in_if.red_sample, in_if.time_ms);
    end

    always @(posedge i_clk) begin
        t_beat_result got;
        if (out_if.valid && out_if.ready) begin
            got.ev = out_if.event_res; got.rate = out_if.beat_rate;
            got.med = out_if.median_rate; got.cnt = out_if.kept_count;
            got.irf = out_if.ir_filtered;
            sb.check(got);
        end
        out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send(input bit [17:0] ir, input bit [17:0] red, input bit [31:0] t);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.ir_sample  <= ir;
        in_if.red_sample <= red;
        in_if.time_ms    <= t;
        do @(posedge i_clk); while (!in_if.ready);
        sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SESSION_EN: sb.en        = val[0];
            REG_REFRACTORY: sb.refr      = 11'(val);
            REG_MAX_JUMP:   sb.max_jump  = 8'(val);
            REG_JUMP_PER_S: sb.jump_ps   = 8'(val);
            REG_MIN_BEATS:  sb.min_beats = 4'(val);
            REG_BPM_LOW:    sb.bpm_lo    = 8'(val);
            REG_BPM_HIGH:   sb.bpm_hi    = 8'(val);
            default: ;
        endcase
    endtask

    task automatic setup(input int en, input int refr, input int mj, input int jps,
                         input int mb, input int lo, input int hi);
        write_reg(REG_SESSION_EN, en);
        write_reg(REG_REFRACTORY, refr);
        write_reg(REG_MAX_JUMP, mj);
        write_reg(REG_JUMP_PER_S, jps);
        write_reg(REG_MIN_BEATS, mb);
        write_reg(REG_BPM_LOW, lo);
        write_reg(REG_BPM_HIGH, hi);
    endtask

    // Triangle-shaped pulse train with red leading or (rarely) opposing infrared.
    task automatic pulse_train(input int n, input bit frozen_time);
        int period, amp, lead, ph, tri_ir, tri_red, base;
        bit invert;
        period = ($urandom_range(9) == 0) ? $urandom_range(25, 160) : $urandom_range(50, 110);
        amp    = $urandom_range(300, 100000);
        lead   = $urandom_range(0, 120);
        invert = ($urandom_range(7) == 0);
        base   = $urandom_range(110000, 150000);
        for (int k = 0; k < n; k++) begin
            ph = (k * 1024 / period) % 1024;
            tri_ir = (ph < 512) ? ph - 256 : 768 - ph;
            ph = (ph + lead) % 1024;
            tri_red = (ph < 512) ? ph - 256 : 768 - ph;
            if (invert) tri_red = -tri_red;
            if (!frozen_time) clock_ms += $urandom_range(6, 14);
            send(18'(base + amp * tri_ir / 256 + int'($urandom_range(0, 3))),
                 18'(base + amp * tri_red / 256 + int'($urandom_range(0, 3))), clock_ms);
        end
    endtask

    task automatic noise(input int n);
        for (int k = 0; k < n; k++) begin
            clock_ms = ($urandom_range(3) == 0) ? $urandom() : clock_ms + $urandom_range(0, 40);
            send(18'($urandom()), 18'($urandom()), clock_ms);
        end
    endtask

    task automatic random_phase(input int n);
        int done;
        done = 0;
        while (done < n) begin
            if ($urandom_range(9) == 0) begin
                noise(5); done += 5;
            end else begin
                pulse_train(100, 1'b0); done += 100;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        in_if.valid = 1'b0; in_if.ir_sample = '0; in_if.red_sample = '0; in_if.time_ms = '0;
        out_if.ready = 1'b0;
        hold_off = 0; errors = 0; sent = 0; clock_ms = 0;
        send_idle_pct = 22; recv_stall_pct = 68;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, wrap of the time stamp, idle session
        send(0, 0, 0);
        send(18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
        send(0, 18'h3FFFF, 0);
        send(18'h3FFFF, 0, 32'h8000_0000);
        send(18'h2AAAA, 18'h15555, 32'h5555_5555);
        send(18'h15555, 18'h2AAAA, 32'hAAAA_AAAA);
        drain();
        write_reg(REG_SESSION_EN, 0);
        send(18'h3FFFF, 18'h3FFFF, 12);
        send(0, 0, 24);
        drain();
        write_reg(REG_SESSION_EN, 1);
        clock_ms = 32'hFFFF_F000;
        pulse_train(13, 1'b0);
        drain();

        // zero interval: refractory off, time stamp frozen
        setup(1, 0, 255, 255, 0, 0, 255);
        pulse_train(120, 1'b1);
        random_phase(200);
        drain();

        setup(1, 300, 10, 5, 3, 42, 220);
        random_phase(400);
        drain();

        send_idle_pct = 68; recv_stall_pct = 22;
        setup(1, 2000, 0, 0, 9, 255, 0);
        random_phase(100);
        drain();
        setup(1, 250, 0, 255, 1, 30, 230);
        random_phase(300);
        drain();
        setup(1, 200, 3, 0, 12, 0, 255);
        random_phase(200);
        drain();

        send_idle_pct = 0; recv_stall_pct = 0;
        setup(1, 350, 20, 10, 5, 50, 180);
        random_phase(400);

        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // long receiver hold-off while samples keep coming
    initial begin
        while (sent < 40) @(posedge i_clk);
        hold_off = 1;
        repeat (600) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
